### hdl/pse_pkg.sv
`default_nettype none
package pse_pkg;

  // field widths
  localparam int unsigned OPC_W = 3;
  localparam int unsigned VAL_W = 14;
  localparam int unsigned DEP_W = 5;
  localparam int unsigned STS_W = 3;
  // raw operator result: full 14 x 14 product
  localparam int unsigned RES_W = 2 * VAL_W;

  // largest value an entry holds
  localparam logic [VAL_W-1:0] VAL_MAX = VAL_W'(9999);

  // token codes
  typedef enum logic [OPC_W-1:0] {
    OPC_PUSH = 3'd0,
    OPC_ADD  = 3'd1,
    OPC_DIFF = 3'd2,
    OPC_MUL  = 3'd3
  } opcode_t;

  // status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK      = 3'd0,
    ST_UNDER   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_FULL    = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_WB   = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### hdl/postfix_stack_evaluator.sv
`default_nettype none
// Postfix evaluator on a bounded operand stack of STACK_DEPTH entries held in
// a synchronous memory, with the top entry also kept in a register. Each
// accepted word yields exactly one result word: the top of stack (0 when
// empty), the depth and a status code. A push or an error token goes from
// acceptance straight to the output state, which loads its result word into
// the output register once that is free. An add, absolute difference or
// multiply passes through the execute and write-back states first, for the
// registered memory read of the second entry and for registering the
// operator result ahead of the clamp to 9999.
// One word is in work at a time. The next word is taken once the result has
// moved into the output register, so a waiting result does not stall the
// following word's arithmetic. Stack contents are undefined after reset; only
// the depth is cleared, so no clearing pass is needed.
module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire                          clk,
  input  wire                          rst_n,
  // token channel
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [pse_pkg::OPC_W-1:0]    in_opcode,
  input  wire  [pse_pkg::VAL_W-1:0]    in_operand_value,
  // result channel
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [pse_pkg::VAL_W-1:0]    out_top_value,
  output logic [pse_pkg::DEP_W-1:0]    out_depth,
  output logic [pse_pkg::STS_W-1:0]    out_status
);
  import pse_pkg::*;

  localparam int unsigned AW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SP_W = $clog2(STACK_DEPTH + 1);

  // control and payload registers
  state_t               state_r, state_nxt;
  logic [SP_W-1:0]      sp_r, sp_nxt;
  logic [VAL_W-1:0]     top_r, top_nxt;
  logic [OPC_W-1:0]     op_r, op_nxt;
  logic [RES_W-1:0]     res_r, res_nxt;
  status_t              sts_r, sts_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]     out_top_r, out_top_nxt;
  logic [DEP_W-1:0]     out_depth_r, out_depth_nxt;
  status_t              out_sts_r, out_sts_nxt;

  // operand memory
  logic [VAL_W-1:0]     mem [STACK_DEPTH];
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [VAL_W-1:0]     mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [VAL_W-1:0]     rd_data_r;

  logic                 in_acc;
  logic                 out_free;
  logic [SP_W-1:0]      sp_m2;
  logic [VAL_W-1:0]     clamped;
  logic                 sat;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign sp_m2    = sp_r - SP_W'(2);

  // clamp of the registered operator result
  assign sat     = (res_r > RES_W'(VAL_MAX));
  assign clamped = sat ? VAL_MAX : res_r[VAL_W-1:0];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sp_nxt        = sp_r;
    top_nxt       = top_r;
    op_nxt        = op_r;
    res_nxt       = res_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_top_nxt   = out_top_r;
    out_depth_nxt = out_depth_r;
    out_sts_nxt   = out_sts_r;
    mem_we        = 1'b0;
    mem_waddr     = sp_r[AW-1:0];
    mem_wdata     = top_r;
    mem_raddr     = sp_m2[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_opcode;
          sts_nxt   = ST_OK;
          state_nxt = S_OUT;
          priority if (in_opcode == OPC_PUSH) begin
            if (sp_r >= SP_W'(STACK_DEPTH)) begin
              sts_nxt = ST_FULL;
            end else begin
              if (in_operand_value > VAL_MAX) begin
                mem_wdata = VAL_MAX;
                sts_nxt   = ST_SAT;
              end else begin
                mem_wdata = in_operand_value;
              end
              mem_we  = 1'b1;
              top_nxt = mem_wdata;
              sp_nxt  = sp_r + SP_W'(1);
            end
          end else if (sp_r < SP_W'(2)) begin
            sts_nxt = ST_UNDER;
          end else if (in_opcode > OPC_MUL) begin
            sts_nxt = ST_UNKNOWN;
          end else begin
            // second entry comes back from memory next cycle
            state_nxt = S_EXEC;
          end
        end
      end
      S_EXEC: begin
        // a is the cached top, b the entry below it
        priority if (op_r == OPC_ADD) begin
          res_nxt = RES_W'(top_r) + RES_W'(rd_data_r);
        end else if (op_r == OPC_DIFF) begin
          res_nxt = (top_r >= rd_data_r) ? RES_W'(top_r - rd_data_r)
                                         : RES_W'(rd_data_r - top_r);
        end else begin
          res_nxt = RES_W'(top_r) * RES_W'(rd_data_r);
        end
        state_nxt = S_WB;
      end
      S_WB: begin
        // replace the two top entries with the clamped result
        mem_we    = 1'b1;
        mem_waddr = sp_m2[AW-1:0];
        mem_wdata = clamped;
        top_nxt   = clamped;
        sp_nxt    = sp_r - SP_W'(1);
        if (sat) begin
          sts_nxt = ST_SAT;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_top_nxt   = (sp_r == '0) ? '0 : top_r;
          out_depth_nxt = DEP_W'(sp_r);
          out_sts_nxt   = sts_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_r       <= top_nxt;
    op_r        <= op_nxt;
    res_r       <= res_nxt;
    sts_r       <= sts_nxt;
    out_top_r   <= out_top_nxt;
    out_depth_r <= out_depth_nxt;
    out_sts_r   <= out_sts_nxt;
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[mem_raddr];
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_top_value = out_top_r;
  assign out_depth     = out_depth_r;
  assign out_status    = out_sts_r;

`ifndef SYNTHESIS
  // depth never passes the stack size
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // an operator write-back pops exactly one entry
  a_wb_pop: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WB |=> sp_r == $past(sp_r) - SP_W'(1))
    else $error("write-back did not pop one entry");

  // a new result word only comes from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt && !(out_valid_r && out_stall) |-> state_r == S_OUT)
    else $error("result loaded outside output state");

  // an operator reaches execute only with two entries held
  a_exec_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> sp_r >= SP_W'(2))
    else $error("operator executed on short stack");
`endif

endmodule
`default_nettype wire
